### hdl/kanayama_tracking_controller_defines.svh
// ----------------------------------------------------------------------------
// Kanayama tracking controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KANAYAMA_TRACKING_CONTROLLER_DEFINES_SVH
`define KANAYAMA_TRACKING_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define KTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define KTC_ASSERT_DLY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

### hdl/ktc_pkg.sv
// ----------------------------------------------------------------------------
// Kanayama tracking controller package
// Transaction types, fixed-point constants and shared helper functions.
// ----------------------------------------------------------------------------
package ktc_pkg;

    typedef struct packed {
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_heading;
        logic signed [31:0] ref_speed;
        logic signed [31:0] ref_rate;
        logic signed [31:0] heading_offset;
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic signed [31:0] est_heading;
        logic signed [31:0] plain_speed;
        logic signed [31:0] plain_rate;
        logic               is_turn;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_speed;
        logic signed [31:0] out_rate;
        logic signed [31:0] local_ref_x;
        logic signed [31:0] local_ref_y;
        logic signed [31:0] local_ref_heading;
        logic               law_active;
    } result_t;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_ENABLE_LAW   = 2'd0;
    localparam logic [1:0] REG_GAIN_X       = 2'd1;
    localparam logic [1:0] REG_GAIN_Y       = 2'd2;
    localparam logic [1:0] REG_GAIN_HEADING = 2'd3;

    // Angles in 2^-24 rad
    localparam logic signed [27:0] PI_FX      = 28'sd52707179;
    localparam logic signed [27:0] TWO_PI_FX  = 28'sd105414358;
    localparam logic signed [27:0] HALF_PI_FX = 28'sd26353589;

    localparam logic signed [33:0] CORDIC_K  = 34'sd652032875;
    localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
    localparam int                 CORDIC_STEPS = 24;
    localparam int                 REDUCE_STEPS = 7;
    // abs + reduction + wrap + fold + rotations + output
    localparam int                 CORDIC_LAT = REDUCE_STEPS + CORDIC_STEPS + 4;

    localparam logic signed [31:0] SLOW_SPEED = 32'sd655360;

    function automatic logic signed [27:0] atan_at(input logic [4:0] i);
        case (i)
            5'd0:    return 28'sd13176795;
            5'd1:    return 28'sd7778716;
            5'd2:    return 28'sd4110060;
            5'd3:    return 28'sd2086331;
            5'd4:    return 28'sd1047214;
            5'd5:    return 28'sd524117;
            5'd6:    return 28'sd262123;
            5'd7:    return 28'sd131069;
            5'd8:    return 28'sd65536;
            5'd9:    return 28'sd32768;
            5'd10:   return 28'sd16384;
            5'd11:   return 28'sd8192;
            5'd12:   return 28'sd4096;
            5'd13:   return 28'sd2048;
            5'd14:   return 28'sd1024;
            5'd15:   return 28'sd512;
            5'd16:   return 28'sd256;
            5'd17:   return 28'sd128;
            5'd18:   return 28'sd64;
            5'd19:   return 28'sd32;
            5'd20:   return 28'sd16;
            5'd21:   return 28'sd8;
            5'd22:   return 28'sd4;
            5'd23:   return 28'sd2;
            default: return 28'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

### hdl/ktc_cordic.sv
// ----------------------------------------------------------------------------
// Kanayama tracking controller CORDIC
// Pipelined sine and cosine: angle reduction, folding and one rotation a stage.
// ----------------------------------------------------------------------------
module ktc_cordic
(
    input  logic               clk,
    input  logic signed [32:0] angle,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    logic        [33:0] rem_reg  [0:ktc_pkg::REDUCE_STEPS];
    logic               neg_reg  [0:ktc_pkg::REDUCE_STEPS];
    logic signed [27:0] wrap_reg;
    logic signed [27:0] wrap_next;
    logic signed [27:0] fold_next;
    logic               flip_next;
    logic signed [27:0] z_reg    [0:ktc_pkg::CORDIC_STEPS];
    logic signed [33:0] x_reg    [0:ktc_pkg::CORDIC_STEPS];
    logic signed [33:0] y_reg    [0:ktc_pkg::CORDIC_STEPS];
    logic               flip_reg [0:ktc_pkg::CORDIC_STEPS];
    logic signed [33:0] xf_next;
    logic signed [33:0] yf_next;
    logic signed [33:0] ang_ext;

    assign ang_ext = 34'(angle);

    // Magnitude and sign
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= angle[32] ? 34'(-ang_ext) : 34'(ang_ext);
        neg_reg[0] <= angle[32];
    end

    // Restoring remainder by 2*pi, one quotient bit a stage
    for (genvar j = 0; j < ktc_pkg::REDUCE_STEPS; j++)
    begin : g_reduce
        localparam logic [33:0] STEP =
            34'(ktc_pkg::TWO_PI_FX) << (ktc_pkg::REDUCE_STEPS - 1 - j);
        always_ff @(posedge clk)
        begin
            rem_reg[j + 1] <= (rem_reg[j] >= STEP) ? rem_reg[j] - STEP : rem_reg[j];
            neg_reg[j + 1] <= neg_reg[j];
        end
    end

    // Restore sign and wrap into [-pi, pi]
    always_comb
    begin
        wrap_next = $signed(rem_reg[ktc_pkg::REDUCE_STEPS][27:0]);
        if (neg_reg[ktc_pkg::REDUCE_STEPS])
            wrap_next = -wrap_next;
        if (wrap_next > ktc_pkg::PI_FX)
            wrap_next = wrap_next - ktc_pkg::TWO_PI_FX;
        if (wrap_next < -ktc_pkg::PI_FX)
            wrap_next = wrap_next + ktc_pkg::TWO_PI_FX;
    end

    always_ff @(posedge clk)
    begin
        wrap_reg <= wrap_next;
    end

    // Fold into [-pi/2, pi/2], remember to negate the result
    always_comb
    begin
        fold_next = wrap_reg;
        flip_next = 1'b0;
        if (wrap_reg > ktc_pkg::HALF_PI_FX)
        begin
            fold_next = wrap_reg - ktc_pkg::PI_FX;
            flip_next = 1'b1;
        end
        else if (wrap_reg < -ktc_pkg::HALF_PI_FX)
        begin
            fold_next = wrap_reg + ktc_pkg::PI_FX;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg[0]    <= fold_next;
        flip_reg[0] <= flip_next;
        x_reg[0]    <= ktc_pkg::CORDIC_K;
        y_reg[0]    <= '0;
    end

    for (genvar j = 0; j < ktc_pkg::CORDIC_STEPS; j++)
    begin : g_rotate
        localparam logic signed [27:0] ATAN = ktc_pkg::atan_at(5'(j));
        always_ff @(posedge clk)
        begin
            if (z_reg[j] >= 0)
            begin
                x_reg[j + 1] <= x_reg[j] - (y_reg[j] >>> j);
                y_reg[j + 1] <= y_reg[j] + (x_reg[j] >>> j);
                z_reg[j + 1] <= z_reg[j] - ATAN;
            end
            else
            begin
                x_reg[j + 1] <= x_reg[j] + (y_reg[j] >>> j);
                y_reg[j + 1] <= y_reg[j] - (x_reg[j] >>> j);
                z_reg[j + 1] <= z_reg[j] + ATAN;
            end
            flip_reg[j + 1] <= flip_reg[j];
        end
    end

    // Undo the fold and clamp to unit range
    always_comb
    begin
        xf_next = flip_reg[ktc_pkg::CORDIC_STEPS] ? -x_reg[ktc_pkg::CORDIC_STEPS]
                                                  : x_reg[ktc_pkg::CORDIC_STEPS];
        yf_next = flip_reg[ktc_pkg::CORDIC_STEPS] ? -y_reg[ktc_pkg::CORDIC_STEPS]
                                                  : y_reg[ktc_pkg::CORDIC_STEPS];
        if (xf_next > ktc_pkg::ONE_Q30)
            xf_next = ktc_pkg::ONE_Q30;
        if (xf_next < -ktc_pkg::ONE_Q30)
            xf_next = -ktc_pkg::ONE_Q30;
        if (yf_next > ktc_pkg::ONE_Q30)
            yf_next = ktc_pkg::ONE_Q30;
        if (yf_next < -ktc_pkg::ONE_Q30)
            yf_next = -ktc_pkg::ONE_Q30;
    end

    always_ff @(posedge clk)
    begin
        cos_q30 <= 32'(xf_next);
        sin_q30 <= 32'(yf_next);
    end

endmodule

### hdl/kanayama_tracking_controller.sv
// Each accepted transaction raises done once it has passed every pipeline stage.
// Throughput: one transaction per cycle; busy is always low, as the pipeline
// advances every cycle and the receiver cannot hold results off.
// The pipeline has the three 35-stage CORDIC units and nine arithmetic stages.
// Reset clears the valid bits and the configuration registers (all zero).
// ----------------------------------------------------------------------------
// Kanayama tracking controller
// Rotates a reference point into segment-local axes, forms the robot-frame
// pose error, applies the Kanayama tracking law on enabled turns, fully pipelined.
// ----------------------------------------------------------------------------
`include "kanayama_tracking_controller_defines.svh"

module kanayama_tracking_controller
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ktc_pkg::cmd_t            cmd,
    output logic                     done,
    output ktc_pkg::result_t         result,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data
);

    // Front end (3) + CORDIC + arithmetic stages (9) + output register
    localparam int LAT     = 3 + ktc_pkg::CORDIC_LAT + 10;
    localparam int NARITH  = 9;

    // Fields that ride alongside the CORDIC units
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] vd;
        logic signed [31:0] wd;
        logic signed [31:0] ex0;
        logic signed [31:0] ey0;
        logic signed [31:0] ps;
        logic signed [31:0] pr;
        logic               turn;
        logic               slow;
        logic signed [31:0] lh;
    } tail_t;

    typedef struct packed {
        ktc_pkg::cmd_t      cmd;
        logic signed [31:0] lh;
        logic               slow;
        logic signed [32:0] dth;
    } front_t;

    // Working set of the arithmetic stages; each stage fills in its part
    typedef struct packed {
        tail_t              tl;
        logic signed [31:0] co;
        logic signed [31:0] so;
        logic signed [31:0] ck;
        logic signed [31:0] sk;
        logic signed [31:0] ce;
        logic signed [31:0] se;
        logic signed [63:0] m0;
        logic signed [63:0] m1;
        logic signed [63:0] m2;
        logic signed [63:0] m3;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [33:0] exr;
        logic signed [33:0] eyr;
        logic signed [63:0] pv;
        logic signed [65:0] px;
        logic signed [65:0] py;
        logic signed [63:0] ph;
        logic signed [33:0] tv;
        logic signed [49:0] tx;
        logic signed [57:0] ty;
        logic signed [41:0] th;
        logic signed [31:0] v;
        logic signed [31:0] inner;
        logic signed [63:0] pw;
    } work_t;

    logic               accept;
    logic [LAT-1:0]     vld_reg;

    // Configuration registers
    logic               enable_law_reg;
    logic signed [31:0] gain_x_reg;
    logic signed [31:0] gain_y_reg;
    logic signed [31:0] gain_heading_reg;

    ktc_pkg::cmd_t      s1_reg;
    front_t             s2_reg;
    front_t             s3_reg;
    front_t             s2_next;
    front_t             s3_next;
    tail_t              tail_next;
    tail_t              dly_reg [0:ktc_pkg::CORDIC_LAT-1];

    logic signed [31:0] co_w;
    logic signed [31:0] so_w;
    logic signed [31:0] ck_w;
    logic signed [31:0] sk_w;
    logic signed [31:0] ce_w;
    logic signed [31:0] se_w;

    work_t              wk_reg  [1:NARITH];
    work_t              wk_next [1:NARITH];
    work_t              wk0;
    ktc_pkg::result_t   result_next;
    logic               active;

    // The pipeline never stalls, so a command is taken in every cycle start is high
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes cannot occur with a 2-bit index
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_law_reg   <= 1'b0;
            gain_x_reg       <= '0;
            gain_y_reg       <= '0;
            gain_heading_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ktc_pkg::REG_ENABLE_LAW:   enable_law_reg   <= cfg_data[0];
                ktc_pkg::REG_GAIN_X:       gain_x_reg       <= cfg_data;
                ktc_pkg::REG_GAIN_Y:       gain_y_reg       <= cfg_data;
                ktc_pkg::REG_GAIN_HEADING: gain_heading_reg <= cfg_data;
                default:                   enable_law_reg   <= enable_law_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: advance one place every cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Front end: capture, local heading and slow flag, heading error
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_next      = '0;
        s2_next.cmd  = s1_reg;
        s2_next.lh   = ktc_pkg::sat32(66'(s1_reg.ref_heading) - 66'(s1_reg.heading_offset));
        s2_next.slow = (s1_reg.plain_speed < ktc_pkg::SLOW_SPEED);

        s3_next      = s2_reg;
        // Drop the heading error when moving slowly
        s3_next.dth  = s2_reg.slow ? 33'sd0 : 33'(s2_reg.lh) - 33'(s2_reg.cmd.est_heading);
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= cmd;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    // ------------------------------------------------------------------
    // Three sine/cosine units run side by side: segment offset, estimated
    // heading and heading error. Hold the other fields in a delay line.
    // ------------------------------------------------------------------
    ktc_cordic u_cordic_off
    (
        .clk     (clk),
        .angle   (33'(s3_reg.cmd.heading_offset)),
        .cos_q30 (co_w),
        .sin_q30 (so_w)
    );

    ktc_cordic u_cordic_est
    (
        .clk     (clk),
        .angle   (33'(s3_reg.cmd.est_heading)),
        .cos_q30 (ck_w),
        .sin_q30 (sk_w)
    );

    ktc_cordic u_cordic_err
    (
        .clk     (clk),
        .angle   (s3_reg.dth),
        .cos_q30 (ce_w),
        .sin_q30 (se_w)
    );

    always_comb
    begin
        tail_next.rx   = s3_reg.cmd.ref_x;
        tail_next.ry   = s3_reg.cmd.ref_y;
        tail_next.vd   = s3_reg.cmd.ref_speed;
        tail_next.wd   = s3_reg.cmd.ref_rate;
        tail_next.ex0  = s3_reg.cmd.est_x;
        tail_next.ey0  = s3_reg.cmd.est_y;
        tail_next.ps   = s3_reg.cmd.plain_speed;
        tail_next.pr   = s3_reg.cmd.plain_rate;
        tail_next.turn = s3_reg.cmd.is_turn;
        tail_next.slow = s3_reg.slow;
        tail_next.lh   = s3_reg.lh;
    end

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= tail_next;
        for (int i = 1; i < ktc_pkg::CORDIC_LAT; i++)
            dly_reg[i] <= dly_reg[i-1];
    end

    // ------------------------------------------------------------------
    // Arithmetic stages, multiplies or wide adds in each stage, never both
    // ------------------------------------------------------------------
    always_comb
    begin
        wk0    = '0;
        wk0.tl = dly_reg[ktc_pkg::CORDIC_LAT-1];
        wk0.co = co_w;
        wk0.so = so_w;
        wk0.ck = ck_w;
        wk0.sk = sk_w;
        wk0.ce = ce_w;
        wk0.se = se_w;
    end

    always_comb
    begin
        // Rotation products for the segment-local reference
        wk_next[1]    = wk0;
        wk_next[1].m0 = 64'(wk0.co) * 64'(wk0.tl.rx);
        wk_next[1].m1 = 64'(wk0.so) * 64'(wk0.tl.ry);
        wk_next[1].m2 = 64'(wk0.so) * 64'(wk0.tl.rx);
        wk_next[1].m3 = 64'(wk0.co) * 64'(wk0.tl.ry);

        // Round to Q16 and saturate
        wk_next[2]    = wk_reg[1];
        wk_next[2].lx = ktc_pkg::sat32(66'((wk_reg[1].m0 + wk_reg[1].m1
                                            + 64'sd536870912) >>> 30));
        wk_next[2].ly = ktc_pkg::sat32(66'((wk_reg[1].m3 - wk_reg[1].m2
                                            + 64'sd536870912) >>> 30));

        // Position error, zeroed when slow
        wk_next[3]    = wk_reg[2];
        wk_next[3].dx = wk_reg[2].tl.slow ? 32'sd0
                      : ktc_pkg::sat32(66'(wk_reg[2].lx) - 66'(wk_reg[2].tl.ex0));
        wk_next[3].dy = wk_reg[2].tl.slow ? 32'sd0
                      : ktc_pkg::sat32(66'(wk_reg[2].ly) - 66'(wk_reg[2].tl.ey0));

        // Robot-frame rotation products
        wk_next[4]    = wk_reg[3];
        wk_next[4].m0 = 64'(wk_reg[3].ck) * 64'(wk_reg[3].dx);
        wk_next[4].m1 = 64'(wk_reg[3].sk) * 64'(wk_reg[3].dy);
        wk_next[4].m2 = 64'(wk_reg[3].sk) * 64'(wk_reg[3].dx);
        wk_next[4].m3 = 64'(wk_reg[3].ck) * 64'(wk_reg[3].dy);

        wk_next[5]     = wk_reg[4];
        wk_next[5].exr = 34'((wk_reg[4].m0 + wk_reg[4].m1 + 64'sd536870912) >>> 30);
        wk_next[5].eyr = 34'((wk_reg[4].m3 - wk_reg[4].m2 + 64'sd536870912) >>> 30);

        // Law products
        wk_next[6]    = wk_reg[5];
        wk_next[6].pv = 64'(wk_reg[5].tl.vd) * 64'(wk_reg[5].ce);
        wk_next[6].px = 66'(gain_x_reg) * 66'(wk_reg[5].exr);
        wk_next[6].py = 66'(gain_y_reg) * 66'(wk_reg[5].eyr);
        wk_next[6].ph = 64'(gain_heading_reg) * 64'(wk_reg[5].se);

        // Round each term
        wk_next[7]    = wk_reg[6];
        wk_next[7].tv = 34'((wk_reg[6].pv + 64'sd536870912) >>> 30);
        wk_next[7].tx = 50'((wk_reg[6].px + 66'sd32768) >>> 16);
        wk_next[7].ty = 58'((wk_reg[6].py + 66'sd128) >>> 8);
        wk_next[7].th = 42'((wk_reg[6].ph + 64'sd2097152) >>> 22);

        // Speed command and inner term, both saturated
        wk_next[8]       = wk_reg[7];
        wk_next[8].v     = ktc_pkg::sat32(66'(wk_reg[7].tv) + 66'(wk_reg[7].tx));
        wk_next[8].inner = ktc_pkg::sat32(66'(wk_reg[7].ty) + 66'(wk_reg[7].th));

        wk_next[9]    = wk_reg[8];
        wk_next[9].pw = 64'(wk_reg[8].tl.vd) * 64'(wk_reg[8].inner);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= NARITH; i++)
            wk_reg[i] <= wk_next[i];
    end

    // ------------------------------------------------------------------
    // Output register: turn rate, then pick law or plain commands
    // ------------------------------------------------------------------
    assign active = enable_law_reg & wk_reg[NARITH].tl.turn;

    always_comb
    begin
        result_next.out_speed  = active ? wk_reg[NARITH].v : wk_reg[NARITH].tl.ps;
        result_next.out_rate   = active
            ? ktc_pkg::sat32(66'(wk_reg[NARITH].tl.wd)
                             + 66'((wk_reg[NARITH].pw + 64'sd8388608) >>> 24))
            : wk_reg[NARITH].tl.pr;
        result_next.local_ref_x       = wk_reg[NARITH].lx;
        result_next.local_ref_y       = wk_reg[NARITH].ly;
        result_next.local_ref_heading = wk_reg[NARITH].tl.lh;
        result_next.law_active        = active;
    end

    always_ff @(posedge clk)
    begin
        result <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KTC_ASSERT_DLY(a_fixed_latency, accept, LAT, done, "transaction lost in pipeline")
    `KTC_ASSERT_IMP(a_law_needs_enable, done && result.law_active, enable_law_reg,
                    "law result used while disabled")

endmodule
